// ===== sv/dtvp_pkg.sv =====
// types and constants shared by the decimal text value parser
`timescale 1ns / 1ps

package dtvp_pkg;

   // parse phase, one-hot
   typedef enum logic [3:0] {
      PH_WHOLE = 4'b0001,
      PH_FRAC  = 4'b0010,
      PH_DONE  = 4'b0100,
      PH_ERROR = 4'b1000
   } phase_type;

   // result codes and scale factors
   localparam logic [31:0] ERR_PLAIN   = 32'hFFFF_FFFF;
   localparam logic [31:0] ERR_MILLI   = 32'h0000_FFFF;
   localparam logic [31:0] MILLI_SCALE = 32'd1000;
   localparam logic [31:0] FRAC_MAX    = 32'd999;
   localparam logic [31:0] SCALE_ONE   = 32'd100;
   localparam logic [31:0] SCALE_TWO   = 32'd10;
   localparam logic [31:0] DEC_BASE    = 32'd10;

   // characters
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // digit counter saturates here
   localparam logic [2:0] CNT_SAT = 3'd7;

endpackage

// ===== sv/decimal_text_value_parser.sv =====
// top level of the decimal text value parser
`timescale 1ns / 1ps

// Decimal text value parser.
// The req channel carries one ASCII character per transaction (req_ch);
// a NUL character ends the string and causes one rsp transaction with
// the parsed value (rsp_value) and a malformed flag (rsp_invalid). No
// other character produces a response.
// csr_write_enable/csr_write_data set milli_mode (0 plain integer,
// 1 fixed three-decimal) and restart the string in progress; write only
// while the block is idle.
// Throughput: one character per cycle while no NUL waits on a stalled
// response. The digit update (value*10+digit) and the final
// whole*1000+fraction scaling each fit in the combinational logic
// after the input register. A NUL goes from the input register to the
// result register, which drives rsp. When rsp_stall holds a pending
// response, other characters keep flowing; a NUL waits in the input
// register and req_stall rises until the output register frees.
// Reset (synchronous, active high) clears both registers' valid flags,
// the parse state and milli_mode.
module decimal_text_value_parser #(
   parameter int MAX_MILLI_DIGITS = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_value,
   output logic        rsp_invalid,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   // width of the whole part in milli mode
   localparam int WholeWidth = $clog2(10 ** MAX_MILLI_DIGITS);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_ch_ff;

   // parse state
   logic                    milli_ff;
   logic [31:0]             acc_ff, acc_in;
   logic [2:0]              cnt_ff, cnt_in;
   dtvp_pkg::phase_type     phase_ff, phase_in;
   logic [WholeWidth-1:0]   whole_ff, whole_in;

   // result register
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_value_ff, out_value_in;
   logic        out_invalid_ff, out_invalid_in;

   logic        out_free;
   logic        is_nul;
   logic        advance;
   logic        is_digit;
   logic [31:0] acc_step;
   logic [2:0]  cnt_inc;
   logic        too_many;
   logic [31:0] frac_val;
   logic [31:0] frac_scaled;
   logic [31:0] mul_src;
   logic [31:0] milli_total;

   // handshake
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign is_nul    = (in_ch_ff == dtvp_pkg::CH_NUL);
   assign advance   = in_valid_ff && (!is_nul || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign in_valid_in = (req_valid && !req_stall) || (in_valid_ff && !advance);

   // character classes and digit arithmetic
   assign is_digit = (in_ch_ff >= dtvp_pkg::CH_ZERO) && (in_ch_ff <= dtvp_pkg::CH_NINE);
   assign acc_step = 32'(acc_ff * dtvp_pkg::DEC_BASE) + {28'd0, in_ch_ff[3:0]};
   assign cnt_inc  = (cnt_ff == dtvp_pkg::CNT_SAT) ? cnt_ff : cnt_ff + 3'd1;
   assign too_many = (cnt_inc > 3'(MAX_MILLI_DIGITS));

   // fraction scaling to thousandths
   assign frac_val = {22'd0, acc_ff[9:0]};
   always_comb begin
      case (cnt_ff)
         3'd1:    frac_scaled = 32'(frac_val * dtvp_pkg::SCALE_ONE);
         3'd2:    frac_scaled = 32'(frac_val * dtvp_pkg::SCALE_TWO);
         default: frac_scaled = frac_val;
      endcase
   end

   // shared times-1000 path: accumulator in whole phase, else whole part
   assign mul_src = (phase_ff == dtvp_pkg::PH_WHOLE) ? acc_ff
                                                      : 32'(whole_ff);
   assign milli_total = 32'(mul_src * dtvp_pkg::MILLI_SCALE) +
                        ((phase_ff == dtvp_pkg::PH_FRAC) ? frac_scaled : 32'd0);

   // next parse state and result
   always_comb begin
      acc_in         = acc_ff;
      cnt_in         = cnt_ff;
      phase_in       = phase_ff;
      whole_in       = whole_ff;
      out_valid_in   = out_valid_ff && rsp_stall;
      out_value_in   = out_value_ff;
      out_invalid_in = out_invalid_ff;

      if (advance) begin
         if (is_nul) begin
            // end of string: deliver and restart
            out_valid_in   = 1'b1;
            out_invalid_in = 1'b0;
            if (phase_ff == dtvp_pkg::PH_ERROR) begin
               out_value_in   = milli_ff ? dtvp_pkg::ERR_MILLI : dtvp_pkg::ERR_PLAIN;
               out_invalid_in = 1'b1;
            end else if (!milli_ff || phase_ff == dtvp_pkg::PH_DONE) begin
               out_value_in = acc_ff;
            end else begin
               out_value_in = milli_total;
            end
            acc_in   = 32'd0;
            cnt_in   = 3'd0;
            phase_in = dtvp_pkg::PH_WHOLE;
            whole_in = '0;
         end else if (!milli_ff) begin
            // plain integer
            if (phase_ff == dtvp_pkg::PH_WHOLE) begin
               if (is_digit) begin
                  acc_in = acc_step;
               end else if (in_ch_ff == dtvp_pkg::CH_SPACE) begin
                  phase_in = dtvp_pkg::PH_DONE;
               end else begin
                  phase_in = dtvp_pkg::PH_ERROR;
               end
            end
         end else begin
            // milli mode
            case (phase_ff)
               dtvp_pkg::PH_WHOLE: begin
                  if (is_digit) begin
                     cnt_in = cnt_inc;
                     if (too_many) phase_in = dtvp_pkg::PH_ERROR;
                     else          acc_in   = acc_step;
                  end else if (in_ch_ff == dtvp_pkg::CH_DOT) begin
                     whole_in = acc_ff[WholeWidth-1:0];
                     acc_in   = 32'd0;
                     cnt_in   = 3'd0;
                     phase_in = dtvp_pkg::PH_FRAC;
                  end else begin
                     phase_in = dtvp_pkg::PH_ERROR;
                  end
               end
               dtvp_pkg::PH_FRAC: begin
                  if (is_digit) begin
                     cnt_in = cnt_inc;
                     if (too_many) begin
                        phase_in = dtvp_pkg::PH_ERROR;
                     end else begin
                        acc_in = acc_step;
                        if (acc_step > dtvp_pkg::FRAC_MAX) phase_in = dtvp_pkg::PH_ERROR;
                     end
                  end else begin
                     acc_in   = milli_total;
                     phase_in = dtvp_pkg::PH_DONE;
                  end
               end
               default: begin
                  // done or error: ignore until NUL
               end
            endcase
         end
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         milli_ff     <= 1'b0;
         acc_ff       <= 32'd0;
         cnt_ff       <= 3'd0;
         phase_ff     <= dtvp_pkg::PH_WHOLE;
         whole_ff     <= '0;
      end else if (csr_write_enable) begin
         milli_ff     <= csr_write_data;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_ff && rsp_stall;
         acc_ff       <= 32'd0;
         cnt_ff       <= 3'd0;
         phase_ff     <= dtvp_pkg::PH_WHOLE;
         whole_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         phase_ff     <= phase_in;
         whole_ff     <= whole_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ch_ff <= req_ch;
      end
      out_value_ff   <= out_value_in;
      out_invalid_ff <= out_invalid_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_value   = out_value_ff;
   assign rsp_invalid = out_invalid_ff;

endmodule

// ===== sim/tb_decimal_text_value_parser.sv =====
// testbench for the decimal text value parser: random strings, both modes, checked results
`timescale 1ns / 1ps

module tb_decimal_text_value_parser;

   localparam int MILLI_DIGITS = 3;
   localparam int CHUNK_CHARS  = 80;

   typedef struct packed {
      logic [31:0] value;
      logic        invalid;
   } parse_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_ch = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_value;
   logic        rsp_invalid;
   logic        csr_write_enable = 1'b0;
   logic        csr_write_data = 1'b0;

   // stimulus and expectation stores
   logic [7:0]       pending_chars[$];
   parse_result_type expected_values[$];

   int  send_idle_pct = 24;
   int  rsp_stall_pct = 74;
   int  hold_cycles = 0;
   int  chars_pushed = 0;
   int  chars_taken = 0;
   int  values_checked = 0;
   int  mismatches = 0;
   bit  char_taken = 1'b0;

   // predictor state
   logic [31:0]         acc_value;
   logic [2:0]          digit_cnt;
   dtvp_pkg::phase_type parse_phase;
   logic [31:0]         whole_value;
   logic                milli_sel;

   decimal_text_value_parser #(
      .MAX_MILLI_DIGITS(MILLI_DIGITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_ch(req_ch),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_value(rsp_value),
      .rsp_invalid(rsp_invalid),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // start a new string in the predictor
   function automatic void restart_string();
      acc_value = 32'd0;
      digit_cnt = 3'd0;
      parse_phase = dtvp_pkg::PH_WHOLE;
      whole_value = 32'd0;
   endfunction

   // fraction digits scaled to thousandths
   function automatic logic [31:0] frac_thousandths(input logic [31:0] f, input logic [2:0] n);
      if (n == 3'd1)
         return f * dtvp_pkg::SCALE_ONE;
      else if (n == 3'd2)
         return f * dtvp_pkg::SCALE_TWO;
      return f;
   endfunction

   // advance the parse by one character, queue a value on NUL
   function automatic void parse_char(input logic [7:0] c);
      logic             is_digit;
      logic [31:0]      d;
      parse_result_type r;
      is_digit = (c >= dtvp_pkg::CH_ZERO) && (c <= dtvp_pkg::CH_NINE);
      d = {24'd0, c - dtvp_pkg::CH_ZERO};
      r.invalid = 1'b0;
      if (c == dtvp_pkg::CH_NUL) begin
         if (parse_phase == dtvp_pkg::PH_ERROR) begin
            r.value = milli_sel ? dtvp_pkg::ERR_MILLI : dtvp_pkg::ERR_PLAIN;
            r.invalid = 1'b1;
         end else if (!milli_sel || parse_phase == dtvp_pkg::PH_DONE) begin
            r.value = acc_value;
         end else if (parse_phase == dtvp_pkg::PH_WHOLE) begin
            r.value = acc_value * dtvp_pkg::MILLI_SCALE;
         end else begin
            r.value = whole_value * dtvp_pkg::MILLI_SCALE +
                      frac_thousandths(acc_value, digit_cnt);
         end
         expected_values.push_back(r);
         restart_string();
      end else if (parse_phase == dtvp_pkg::PH_ERROR || parse_phase == dtvp_pkg::PH_DONE) begin
         // rest of the string is ignored
      end else if (!milli_sel) begin
         if (is_digit)
            acc_value = acc_value * dtvp_pkg::DEC_BASE + d;
         else if (c == dtvp_pkg::CH_SPACE)
            parse_phase = dtvp_pkg::PH_DONE;
         else
            parse_phase = dtvp_pkg::PH_ERROR;
      end else if (parse_phase == dtvp_pkg::PH_WHOLE) begin
         if (is_digit) begin
            if (digit_cnt < dtvp_pkg::CNT_SAT)
               digit_cnt = digit_cnt + 3'd1;
            if (digit_cnt > MILLI_DIGITS)
               parse_phase = dtvp_pkg::PH_ERROR;
            else
               acc_value = acc_value * dtvp_pkg::DEC_BASE + d;
         end else if (c == dtvp_pkg::CH_DOT) begin
            whole_value = acc_value;
            acc_value = 32'd0;
            digit_cnt = 3'd0;
            parse_phase = dtvp_pkg::PH_FRAC;
         end else begin
            parse_phase = dtvp_pkg::PH_ERROR;
         end
      end else begin
         // fraction digits
         if (is_digit) begin
            if (digit_cnt < dtvp_pkg::CNT_SAT)
               digit_cnt = digit_cnt + 3'd1;
            if (digit_cnt > MILLI_DIGITS) begin
               parse_phase = dtvp_pkg::PH_ERROR;
            end else begin
               acc_value = acc_value * dtvp_pkg::DEC_BASE + d;
               if (acc_value > dtvp_pkg::FRAC_MAX)
                  parse_phase = dtvp_pkg::PH_ERROR;
            end
         end else begin
            acc_value = whole_value * dtvp_pkg::MILLI_SCALE +
                        frac_thousandths(acc_value, digit_cnt);
            parse_phase = dtvp_pkg::PH_DONE;
         end
      end
   endfunction

   // character source: hold until taken, idle at random
   always @(negedge clock) begin : drive_chars
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || char_taken) begin
         if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_ch <= pending_chars.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // accepted character transactions feed the predictor
   always @(posedge clock) begin : track_chars
      char_taken = req_valid && !req_stall && !reset;
      if (char_taken) begin
         parse_char(req_ch);
         chars_taken++;
      end
   end

   // result stall: long hold when requested, random otherwise
   always @(negedge clock) begin : pace_rsp
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   task automatic flag_result(input string why, input logic [31:0] ev, input logic ei);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch (%s) at %0t: expected value %h invalid %b, got value %h invalid %b",
                  why, $realtime, ev, ei, rsp_value, rsp_invalid);
   endtask

   // result transactions against the oldest expectation
   always @(posedge clock) begin : check_values
      parse_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         values_checked++;
         if (expected_values.size() == 0) begin
            flag_result("no value expected", 32'd0, 1'b0);
         end else begin
            e = expected_values.pop_front();
            if (rsp_value !== e.value || rsp_invalid !== e.invalid)
               flag_result("wrong field", e.value, e.invalid);
         end
      end
   end

   task automatic push_char(input logic [7:0] c);
      pending_chars.push_back(c);
      chars_pushed++;
   endtask

   task automatic push_text(input string s, input bit terminate);
      for (int i = 0; i < s.len(); i++)
         push_char(s[i]);
      if (terminate)
         push_char(dtvp_pkg::CH_NUL);
   endtask

   task automatic push_digits(input int n);
      for (int i = 0; i < n; i++)
         push_char(dtvp_pkg::CH_ZERO + 8'($urandom_range(9)));
   endtask

   task automatic push_noise(input int n);
      for (int i = 0; i < n; i++)
         push_char(8'($urandom_range(1, 255)));
   endtask

   // nonzero non-digit character other than skip
   function automatic logic [7:0] pick_other(input logic [7:0] skip);
      logic [7:0] c;
      c = 8'($urandom_range(1, 255));
      while ((c >= dtvp_pkg::CH_ZERO && c <= dtvp_pkg::CH_NINE) || c == skip)
         c = 8'($urandom_range(1, 255));
      return c;
   endfunction

   // plain integer string, mostly digits, sometimes space or bad tail
   task automatic add_plain_string();
      int kind;
      kind = $urandom_range(9);
      if (kind == 9) begin
         push_noise($urandom_range(1, 6));
      end else begin
         push_digits($urandom_range(0, 12));
         if (kind == 6 || kind == 7) begin
            push_char(dtvp_pkg::CH_SPACE);
            push_noise($urandom_range(0, 3));
         end else if (kind == 8) begin
            push_char(pick_other(dtvp_pkg::CH_SPACE));
            push_noise($urandom_range(0, 3));
         end
      end
      push_char(dtvp_pkg::CH_NUL);
   endtask

   // fixed-point string, mostly well formed
   task automatic add_milli_string();
      int kind;
      kind = $urandom_range(9);
      if (kind <= 6) begin
         push_digits($urandom_range(0, 3));
         if ($urandom_range(3) != 0) begin
            push_char(dtvp_pkg::CH_DOT);
            push_digits($urandom_range(0, 3));
            if ($urandom_range(3) == 0) begin
               push_char(pick_other(dtvp_pkg::CH_NUL));
               push_noise($urandom_range(0, 3));
            end
         end
      end else if (kind == 7) begin
         push_digits($urandom_range(4, 6));
         if ($urandom_range(1) != 0) begin
            push_char(dtvp_pkg::CH_DOT);
            push_digits($urandom_range(0, 3));
         end
      end else if (kind == 8) begin
         push_digits($urandom_range(0, 3));
         push_char(dtvp_pkg::CH_DOT);
         push_digits($urandom_range(4, 5));
      end else if ($urandom_range(1) != 0) begin
         push_digits($urandom_range(0, 3));
         push_char(pick_other(dtvp_pkg::CH_DOT));
         push_noise($urandom_range(0, 3));
      end else begin
         push_noise($urandom_range(1, 6));
      end
      push_char(dtvp_pkg::CH_NUL);
   endtask

   // all characters taken, all values back, then let the pipe settle
   task automatic wait_idle();
      while (chars_taken != chars_pushed || expected_values.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_mode(input logic m);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= m;
      @(posedge clock);
      milli_sel = m;
      restart_string();
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // main sequence
   initial begin : run_stimulus
      int start;
      milli_sel = 1'b0;
      restart_string();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed plain strings: empty, space tail, bad top character
      push_text("", 1);
      push_text("7 x", 1);
      push_text("1", 0);
      push_char(8'hFF);
      push_char(dtvp_pkg::CH_NUL);
      // unterminated string, dropped by the mode write
      push_text("12", 0);
      wait_idle();
      set_mode(1'b1);

      // directed milli strings: bare dot, two fraction digits with tail,
      // too many whole digits, bad separator, too many fraction digits
      push_text("1.", 1);
      push_text("999.99x", 1);
      push_text("1234", 1);
      push_text("5a", 1);
      push_text(".1234", 1);
      wait_idle();

      // random chunks over both modes and three idling schemes
      for (int k = 0; k < 6; k++) begin
         if (k < 2) begin
            send_idle_pct = 24;
            rsp_stall_pct = 74;
         end else if (k < 4) begin
            send_idle_pct = 74;
            rsp_stall_pct = 24;
         end else begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         set_mode(k[0]);
         if (k == 4)
            hold_cycles = 150;
         start = chars_pushed;
         while (chars_pushed - start < CHUNK_CHARS) begin
            if (milli_sel)
               add_milli_string();
            else
               add_plain_string();
         end
         wait_idle();
      end

      repeat (10) @(posedge clock);
      $display("run covered %0d characters and %0d checked values in plain and milli modes,",
               chars_taken, values_checked);
      $display("with random idling on both sides, a long output hold and %0d mismatches",
               mismatches);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #2_000_000;
      $display("timeout with %0d values outstanding", expected_values.size());
      $display("TB_ERROR");
      $finish;
   end

endmodule
